### hdl/pbc_pkg.sv
// shared types, constants and the div255 helper function for the premultiply/background composite block
// no dependencies; used by pbc_position, pbc_blend and premultiply_background_composite
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 4096;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;

    localparam int unsigned SIZE_W = 13;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0] GRAY_DARK   = 8'h20;
    localparam logic [7:0] GRAY_LIGHT  = 8'h40;
    localparam logic [7:0] CHANNEL_MAX = 8'hFF;
    localparam int unsigned CHECKER_BIT = 3;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd832;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd400;
    localparam logic [31:0]       RESET_SOLID  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        BG_TRANSPARENT = 2'd0,
        BG_CHECKER     = 2'd1,
        BG_SOLID       = 2'd2
    } bg_mode_t;

    localparam bg_mode_t RESET_MODE = BG_CHECKER;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_BACKGROUND_MODE = 2'd2,
        REG_SOLID_COLOR     = 2'd3
    } reg_idx_t;

    // first member is the top byte, so blue sits in bits 7:0
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        bg_mode_t          background_mode;
        logic [31:0]       solid_color;
    } cfg_t;

    // background and frame marker for the pixel being accepted
    typedef struct packed {
        pixel_t bg;
        logic   frame_end;
    } pos_info_t;

    // exact floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

### hdl/pbc_position.sv
// raster column/row counters, background color selection and frame-end marking
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_position #(
    parameter int unsigned MAX_WIDTH  = pbc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = pbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  pbc_pkg::cfg_t      cfg,
    output pbc_pkg::pos_info_t info
);
    import pbc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic          last_col, last_row;
    logic [7:0]    gray;

    // last position of a row/frame, size clamped to 1..max
    always_comb begin
        if (cfg.image_width == '0) begin
            col_last = '0;
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            col_last = CW'(MAX_WIDTH - 1);
        end else begin
            col_last = CW'(32'(cfg.image_width) - 32'd1);
        end
        if (cfg.image_height == '0) begin
            row_last = '0;
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            row_last = RW'(MAX_HEIGHT - 1);
        end else begin
            row_last = RW'(32'(cfg.image_height) - 32'd1);
        end
    end

    assign last_col = col_reg >= col_last;
    assign last_row = row_reg >= row_last;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign gray = (col_reg[CHECKER_BIT] ^ row_reg[CHECKER_BIT]) ? GRAY_DARK : GRAY_LIGHT;

    always_comb begin
        case (cfg.background_mode)
            BG_CHECKER: begin
                info.bg = '{alpha: CHANNEL_MAX, red: gray, green: gray, blue: gray};
            end
            BG_SOLID: begin
                info.bg = pixel_t'(cfg.solid_color);
            end
            default: begin
                info.bg = '0;
            end
        endcase
        info.frame_end = last_col && last_row;
    end

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= CW'(MAX_WIDTH - 1))
        else $error("column counter beyond maximum width");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= RW'(MAX_HEIGHT - 1))
        else $error("row counter beyond maximum height");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && info.frame_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after frame end");
`endif

endmodule

### hdl/pbc_blend.sv
// three-register premultiply and composite datapath with per-stage valid/ready
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_blend (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pbc_pkg::pixel_t    in_pixel,
    input  pbc_pkg::pos_info_t in_info,
    output logic               out_valid,
    input  logic               out_ready,
    output pbc_pkg::pixel_t    out_pixel,
    output logic               out_last
);
    import pbc_pkg::*;

    localparam int unsigned NCH = 3;

    // stage 1: captured pixel and background
    logic   v1_reg;
    pixel_t pix1_reg;
    pixel_t bg1_reg;
    logic   last1_reg;

    // stage 2: products
    logic        v2_reg;
    logic [15:0] prod_c_reg  [NCH];
    logic [15:0] prod_c_next [NCH];
    logic [15:0] prod_bg_reg  [NCH+1];
    logic [15:0] prod_bg_next [NCH+1];
    logic [7:0]  alpha2_reg;
    logic        last2_reg;

    // stage 3: result
    logic   v3_reg;
    pixel_t out_reg, out_next;
    logic   last3_reg;

    logic r1, r2, r3;
    logic [7:0] inv;
    logic [7:0] c1 [NCH];
    logic [7:0] b1 [NCH+1];
    logic [7:0] sum_c [NCH+1];

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    assign inv = CHANNEL_MAX - pix1_reg.alpha;
    assign c1[0] = pix1_reg.blue;
    assign c1[1] = pix1_reg.green;
    assign c1[2] = pix1_reg.red;
    assign b1[0] = bg1_reg.blue;
    assign b1[1] = bg1_reg.green;
    assign b1[2] = bg1_reg.red;
    assign b1[3] = bg1_reg.alpha;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            prod_c_next[i] = 16'(c1[i]) * 16'(pix1_reg.alpha);
        end
        for (int i = 0; i < NCH + 1; i++) begin
            prod_bg_next[i] = 16'(inv) * 16'(b1[i]);
        end
    end

    // src + (255-a)*bg/255; the sum stays within 8 bits
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            sum_c[i] = div255(prod_c_reg[i]) + div255(prod_bg_reg[i]);
        end
        sum_c[NCH] = alpha2_reg + div255(prod_bg_reg[NCH]);
        out_next = '{alpha: sum_c[3], red: sum_c[2], green: sum_c[1], blue: sum_c[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            pix1_reg  <= in_pixel;
            bg1_reg   <= in_info.bg;
            last1_reg <= in_info.frame_end;
        end
        if (r2 && v1_reg) begin
            prod_c_reg  <= prod_c_next;
            prod_bg_reg <= prod_bg_next;
            alpha2_reg  <= pix1_reg.alpha;
            last2_reg   <= last1_reg;
        end
        if (r3 && v2_reg) begin
            out_reg   <= out_next;
            last3_reg <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_pixel = out_reg;
    assign out_last  = last3_reg;

`ifndef SYNTHESIS
    a_hold_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !r2) |=> v1_reg)
        else $error("stage 1 word lost while stage 2 stalled");

    a_hold_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !r3) |=> v2_reg)
        else $error("stage 2 word lost while output stalled");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("result appeared without a stage 2 word");
`endif

endmodule

### hdl/premultiply_background_composite.sv
// top level: configuration registers, raster position tracking and the composite pipeline
// depends on pbc_pkg, pbc_position and pbc_blend
`timescale 1ns / 1ps
//
// channel   direction  ports                          word
// -------   ---------  -----------------------------  -------------------------------
// pixel in  slave      s_tvalid s_tready s_tdata      bgra straight alpha, 32 bits
// pixel out master     m_tvalid m_tready m_tdata      bgra composited, tlast=frame end
// config    apb        psel penable pwrite paddr ...  width, height, mode, solid color
//
// one pixel per clock sustained while m_tready stays high; m_tvalid rises once the word has
// passed the input register, product register and result register
// each stage has its own valid bit, so empty stages keep taking input while a result waits
// synchronous active-low reset clears the valid bits and counters, loads config reset values;
// no clearing pass, the block is ready the cycle after reset is released

module premultiply_background_composite #(
    parameter int unsigned MAX_WIDTH  = pbc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = pbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // pixel input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // in_blue, in_green, in_red, in_alpha
    // composited output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic                         m_tlast,   // frame_end
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [pbc_pkg::DATA_W-1:0]   pwdata,
    output logic [pbc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import pbc_pkg::*;

    // configuration registers
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;
    bg_mode_t          background_mode_reg;
    logic [31:0]       solid_color_reg;

    logic      cfg_write;
    reg_idx_t  reg_idx;
    cfg_t      cfg;
    pos_info_t info;
    pixel_t    out_pixel;
    logic      accept;

    assign pready    = 1'b1;
    // byte address 4*i, word-aligned decode
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= RESET_WIDTH;
            image_height_reg    <= RESET_HEIGHT;
            background_mode_reg <= RESET_MODE;
            solid_color_reg     <= RESET_SOLID;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:     image_width_reg     <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:    image_height_reg    <= pwdata[SIZE_W-1:0];
                REG_BACKGROUND_MODE: background_mode_reg <= bg_mode_t'(pwdata[1:0]);
                REG_SOLID_COLOR:     solid_color_reg     <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:     prdata = DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT:    prdata = DATA_W'(image_height_reg);
            REG_BACKGROUND_MODE: prdata = DATA_W'(background_mode_reg);
            REG_SOLID_COLOR:     prdata = DATA_W'(solid_color_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg = '{
        image_width:     image_width_reg,
        image_height:    image_height_reg,
        background_mode: background_mode_reg,
        solid_color:     solid_color_reg
    };

    assign accept = s_tvalid && s_tready;

    // counters advance on every accepted word; background is taken at accept time
    pbc_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cfg     (cfg),
        .info    (info)
    );

    // premultiply and composite, three registered stages
    pbc_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (pixel_t'(s_tdata)),
        .in_info   (info),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (out_pixel),
        .out_last  (m_tlast)
    );

    assign m_tdata = out_pixel;

endmodule

### verif/premultiply_background_composite_tb.sv
// self-checking testbench for premultiply_background_composite: straight-alpha pixel stream
// in, composited pixels out, predicted in the bench and compared word by word
// depends on pbc_pkg and the premultiply_background_composite rtl
`timescale 1ns / 1ps

module premultiply_background_composite_tb;
    import pbc_pkg::*;

    // generous run limit, far above the length of the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // long receiver hold-off used to fill the pipeline
    localparam int unsigned HOLD_CYCLES  = 300;
    // pipeline depth from accept to m_tvalid, plus margin
    localparam int unsigned SETTLE_CYCLES = 6;
    // the mode encoding with no background of its own; behaves as transparent
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one composited word as the block should emit it
    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } composite_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // blue 7:0, green 15:8, red 23:16, alpha 31:24
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // blue 7:0, green 15:8, red 23:16, alpha 31:24
    logic        m_tlast;          // frame_end
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    premultiply_background_composite dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // bench copy of the block state: register values and raster position
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] cfg_width  = RESET_WIDTH;
    logic [SIZE_W-1:0] cfg_height = RESET_HEIGHT;
    logic [1:0]        cfg_mode   = RESET_MODE;
    logic [31:0]       cfg_solid  = RESET_SOLID;
    int unsigned       col_pos    = 0;
    int unsigned       row_pos    = 0;

    // composited words still owed by the block, oldest first
    composite_t  expected_pixels[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // sender burst shaping
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // set by a test to make the receiver hold off for HOLD_CYCLES
    bit hold_request = 1'b0;

    // truncating x*y/255
    function automatic int unsigned scaled(input int unsigned x, input int unsigned y);
        return (x * y) / 255;
    endfunction

    // src over background channel: src + (255-a)*bg/255
    function automatic logic [7:0] over_bg(input int unsigned src, input int unsigned inv,
                                           input logic [7:0] bg);
        return 8'(src + scaled(inv, bg));
    endfunction

    // expected output for one accepted pixel; advances the raster position
    function automatic composite_t predict_composite(input pixel_t px);
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned a;
        int unsigned inv;
        logic [7:0]  pb;
        logic [7:0]  pg;
        logic [7:0]  pr;
        logic [7:0]  gray;
        logic [31:0] bg;
        logic        last_col;
        logic        last_row;
        composite_t  res;

        a   = px.alpha;
        inv = CHANNEL_MAX - a;
        pb  = 8'(scaled(px.blue, a));
        pg  = 8'(scaled(px.green, a));
        pr  = 8'(scaled(px.red, a));

        // zero size acts as one, oversize saturates
        eff_w = (cfg_width == 0) ? 1 : (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
        eff_h = (cfg_height == 0) ? 1 :
                (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;

        res.px = {px.alpha, pr, pg, pb};
        if (cfg_mode == BG_CHECKER) begin
            gray = (((col_pos ^ row_pos) >> CHECKER_BIT) & 1) ? GRAY_DARK : GRAY_LIGHT;
            bg   = {CHANNEL_MAX, gray, gray, gray};
        end else begin
            bg = cfg_solid;
        end
        // transparent and the unused encoding leave the premultiplied pixel alone
        if (cfg_mode == BG_CHECKER || cfg_mode == BG_SOLID) begin
            res.px.blue  = over_bg(pb, inv, bg[7:0]);
            res.px.green = over_bg(pg, inv, bg[15:8]);
            res.px.red   = over_bg(pr, inv, bg[23:16]);
            res.px.alpha = over_bg(a, inv, bg[31:24]);
        end

        // "at or beyond" so a shrink mid-frame wraps on the next pixel
        last_col      = col_pos >= eff_w - 1;
        last_row      = row_pos >= eff_h - 1;
        res.frame_end = last_col && last_row;

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // apb access helpers
    // ------------------------------------------------------------------
    task automatic read_register(input reg_idx_t idx, input logic [31:0] want);
        logic [31:0] got;

        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // access phase, pready tied high
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("register %s expected %h actual %h", idx.name(), want, got);
            error_count++;
        end
    endtask

    // write, mirror into the bench copy, then read back
    task automatic program_register(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] stored;

        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                cfg_width = value[SIZE_W-1:0];
                stored    = {{(32-SIZE_W){1'b0}}, cfg_width};
            end
            REG_IMAGE_HEIGHT: begin
                cfg_height = value[SIZE_W-1:0];
                stored     = {{(32-SIZE_W){1'b0}}, cfg_height};
            end
            REG_BACKGROUND_MODE: begin
                cfg_mode = value[1:0];
                stored   = {30'd0, cfg_mode};
            end
            default: begin
                cfg_solid = value;
                stored    = value;
            end
        endcase
        read_register(idx, stored);
    endtask

    // ------------------------------------------------------------------
    // pixel sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic send_pixel(input pixel_t px);
        if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // word accepted at this edge
        expected_pixels.push_back(predict_composite(px));
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    // stop sending and let every owed word come out
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // channel value biased toward the ends of its range
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return CHANNEL_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return {random_channel(), random_channel(), random_channel(), random_channel()};
    endfunction

    // mostly small sizes so frames end often, now and then zero or oversize
    function automatic logic [31:0] random_size(input int unsigned typical);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom_range(DEF_MAX_WIDTH + 1, 8191);
            2:       return $urandom_range(typical + 1, DEF_MAX_WIDTH);
            3:       return $urandom;  // upper bits are dropped by the register
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values, then a few pixels against the reset checkerboard
    task automatic test_register_defaults();
        read_register(REG_IMAGE_WIDTH, {{(32-SIZE_W){1'b0}}, RESET_WIDTH});
        read_register(REG_IMAGE_HEIGHT, {{(32-SIZE_W){1'b0}}, RESET_HEIGHT});
        read_register(REG_BACKGROUND_MODE, {30'd0, RESET_MODE});
        read_register(REG_SOLID_COLOR, RESET_SOLID);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'h80C0_4020);
        drain_pipeline();
    endtask

    // premultiply extremes with no background in the way
    task automatic test_premultiply_extremes();
        program_register(REG_BACKGROUND_MODE, BG_TRANSPARENT);
        send_pixel(32'hFFFF_FFFF);   // opaque white passes unchanged
        send_pixel(32'h00FF_FFFF);   // fully transparent color goes to zero
        send_pixel(32'hFF00_0000);   // opaque black
        send_pixel(32'h01FF_00FF);   // alpha one, full channels scale to one
        send_pixel(32'hFE80_7FFF);   // alpha just below opaque
        drain_pipeline();
    endtask

    // each background mode, including the unused encoding
    task automatic test_background_modes();
        logic [1:0] modes[4];

        modes = '{BG_TRANSPARENT, BG_CHECKER, BG_SOLID, MODE_UNUSED};
        program_register(REG_SOLID_COLOR, 32'h8040_2010);
        foreach (modes[i]) begin
            program_register(REG_BACKGROUND_MODE, modes[i]);
            send_pixel(32'h0012_3456);   // transparent pixel shows the background
            send_pixel(32'h7FFF_80FF);   // half coverage blend
            drain_pipeline();
        end
    endtask

    // zero sizes, and a shrink while the raster is mid-row
    task automatic test_degenerate_sizes();
        program_register(REG_IMAGE_WIDTH, 32'd0);
        program_register(REG_IMAGE_HEIGHT, 32'd0);
        send_pixel(random_pixel());   // one-pixel frame, frame_end every word
        send_pixel(random_pixel());
        drain_pipeline();
        program_register(REG_IMAGE_WIDTH, 32'd20);
        program_register(REG_IMAGE_HEIGHT, 32'd5);
        repeat (6) send_pixel(random_pixel());
        drain_pipeline();
        // column now past the new last column, row at the new last row
        program_register(REG_IMAGE_WIDTH, 32'd4);
        program_register(REG_IMAGE_HEIGHT, 32'd1);
        send_pixel(random_pixel());
        send_pixel(random_pixel());
        drain_pipeline();
    endtask

    // oversize width saturates: a stretch of the widest raster with no early wrap
    task automatic test_max_width_row();
        program_register(REG_BACKGROUND_MODE, BG_CHECKER);
        program_register(REG_IMAGE_WIDTH, 32'h1FFF);
        program_register(REG_IMAGE_HEIGHT, 32'd0);
        // realign to column zero first
        program_register(REG_IMAGE_WIDTH, 32'd1);
        send_pixel(random_pixel());
        drain_pipeline();
        program_register(REG_IMAGE_WIDTH, 32'h1FFF);
        repeat (64) send_pixel(random_pixel());
        drain_pipeline();
    endtask

    // random settings per phase, random pixel content
    task automatic test_random_frames();
        logic [1:0] modes[4];
        logic [31:0] solid;

        modes = '{BG_TRANSPARENT, BG_CHECKER, BG_SOLID, MODE_UNUSED};
        for (int phase = 0; phase < 14; phase++) begin
            // registers left alone keep the raster position running across phases
            if (phase == 0 || $urandom_range(0, 1))
                program_register(REG_IMAGE_WIDTH, random_size(40));
            if (phase == 0 || $urandom_range(0, 1))
                program_register(REG_IMAGE_HEIGHT, random_size(12));
            if (phase == 0 || $urandom_range(0, 1))
                program_register(REG_BACKGROUND_MODE, modes[$urandom_range(0, 3)]);
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       solid = 32'h0000_0000;
                    1:       solid = 32'hFFFF_FFFF;
                    default: solid = $urandom;
                endcase
                program_register(REG_SOLID_COLOR, solid);
            end
            repeat ($urandom_range(60, 110)) send_pixel(random_pixel());
            drain_pipeline();
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        program_register(REG_IMAGE_WIDTH, 32'd24);
        program_register(REG_IMAGE_HEIGHT, 32'd3);
        program_register(REG_BACKGROUND_MODE, BG_SOLID);
        hold_request = 1'b1;
        repeat (80) send_pixel(random_pixel());
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern of its own, checks every accepted word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : receive_words
        composite_t  want;
        pixel_t      got_px;
        int unsigned style;
        int unsigned style_left;
        int unsigned hold_left;

        if (!aresetn) begin
            m_tready  <= 1'b0;
            style      = 0;
            style_left = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_px = m_tdata;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word m_tdata %h m_tlast %b", m_tdata, m_tlast);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got_px.blue !== want.px.blue) begin
                        $error("out_blue expected %0d actual %0d", want.px.blue, got_px.blue);
                        error_count++;
                    end
                    if (got_px.green !== want.px.green) begin
                        $error("out_green expected %0d actual %0d", want.px.green,
                               got_px.green);
                        error_count++;
                    end
                    if (got_px.red !== want.px.red) begin
                        $error("out_red expected %0d actual %0d", want.px.red, got_px.red);
                        error_count++;
                    end
                    if (got_px.alpha !== want.px.alpha) begin
                        $error("out_alpha expected %0d actual %0d", want.px.alpha,
                               got_px.alpha);
                        error_count++;
                    end
                    if (m_tlast !== want.frame_end) begin
                        $error("frame_end expected %b actual %b", want.frame_end, m_tlast);
                        error_count++;
                    end
                end
            end

            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end

            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                // switch between always ready, coin flip and mostly stalled
                if (style_left == 0) begin
                    style      = $urandom_range(0, 2);
                    style_left = $urandom_range(16, 128);
                end
                style_left--;
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_defaults();
        test_premultiply_extremes();
        test_background_modes();
        test_degenerate_sizes();
        test_max_width_row();
        test_random_frames();
        test_output_backpressure();

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
